### rtl/rpr_pkg.sv
// ----------------------------------------------------------------------------
// rpr_pkg
// Shared types and constants for the ring packet receiver and forwarder.
// ----------------------------------------------------------------------------
package rpr_pkg;

    localparam logic [7:0] START_BYTE    = 8'hAA;
    localparam logic [7:0] BROADCAST     = 8'h00;
    localparam logic [7:0] DROP_BAD_CHK  = 8'h00;
    localparam logic [7:0] DROP_OVERSIZE = 8'h01;

    localparam logic [1:0] KIND_RING  = 2'd0;
    localparam logic [1:0] KIND_LOCAL = 2'd1;
    localparam logic [1:0] KIND_DROP  = 2'd2;

    localparam int unsigned ADDR_W       = 3;
    localparam logic [0:0]  REG_DEV_ADDR = 1'b0;
    localparam logic [6:0]  DEV_ADDR_RST = 7'd1;

    typedef enum logic [3:0] {
        SEL_START,
        SEL_SRC,
        SEL_DST,
        SEL_SIZE,
        SEL_PAY,
        SEL_CHK,
        SEL_LSRC,
        SEL_LPAY,
        SEL_BAD,
        SEL_BIG
    } t_sel;

    typedef struct packed {
        logic ld_src;
        logic ld_dst;
        logic ld_size;
        logic data_wr;
        logic left_dec;
        logic ld_chk;
        logic rd_rst;
        logic rd_adv;
        logic emit;
        t_sel sel;
        logic last;
    } t_dp_cmd;

    typedef struct packed {
        logic rx_start;
        logic rx_over;
        logic rx_zero;
        logic rx_chk_ok;
        logic left_one;
        logic size_zero;
        logic pay_last;
        logic fwd;
        logic dlv;
        logic out_free;
    } t_dp_sts;

endpackage

### rtl/rpr_rx_if.sv
// ----------------------------------------------------------------------------
// rpr_rx_if
// Received byte channel: valid/ready handshake carrying one ring byte.
// ----------------------------------------------------------------------------
interface rpr_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

### rtl/rpr_res_if.sv
// ----------------------------------------------------------------------------
// rpr_res_if
// Result channel: valid/ready handshake carrying kind, byte and last flag.
// ----------------------------------------------------------------------------
interface rpr_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, output kind, output out_byte, output last, input ready);
    modport sink (input valid, input kind, input out_byte, input last, output ready);
endinterface

### rtl/rpr_dp.sv
// ----------------------------------------------------------------------------
// rpr_dp
// Datapath: frame fields, running check, payload buffer, address register
// and the result output register.
// ----------------------------------------------------------------------------
module rpr_dp
    import rpr_pkg::*;
#(
    parameter int unsigned MAX_PAYLOAD = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [7:0]       i_rx_byte,
    input  t_dp_cmd          i_cmd,
    output t_dp_sts          o_sts,
    input  logic             i_cfg_we,
    input  logic [6:0]       i_cfg_data,
    output logic [6:0]       o_dev_addr,
    rpr_res_if.source        o_res
);

    localparam int unsigned IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    logic [6:0]       r_dev;
    logic [7:0]       r_src;
    logic [7:0]       r_dst;
    logic [7:0]       r_size;
    logic [8:0]       r_left;
    logic [7:0]       r_sum;
    logic [7:0]       r_chk_byte;
    logic [IDX_W-1:0] r_wr_idx;
    logic [IDX_W-1:0] r_rd_idx;
    logic [IDX_W-1:0] n_rd_idx;
    logic [7:0]       r_rd_data;
    logic [7:0]       r_mem [MAX_PAYLOAD];
    logic             r_out_valid;
    logic [1:0]       r_kind;
    logic [7:0]       r_byte;
    logic             r_last;
    logic [1:0]       n_kind;
    logic [7:0]       n_byte;
    logic [7:0]       dev_ext;

    assign dev_ext    = {1'b0, r_dev};
    assign o_dev_addr = r_dev;

    always_comb begin
        o_sts.rx_start  = (i_rx_byte == START_BYTE);
        o_sts.rx_over   = (i_rx_byte > 8'(MAX_PAYLOAD));
        o_sts.rx_zero   = (i_rx_byte == 8'd0);
        o_sts.rx_chk_ok = (i_rx_byte == r_sum);
        o_sts.left_one  = (r_left == 9'd1);
        o_sts.size_zero = (r_size == 8'd0);
        o_sts.pay_last  = ((9'(r_rd_idx) + 9'd1) == {1'b0, r_size});
        o_sts.fwd       = (r_src != dev_ext) && (r_dst != dev_ext);
        o_sts.dlv       = (r_dst == BROADCAST) || (r_dst == dev_ext);
        o_sts.out_free  = !r_out_valid || o_res.ready;
    end

    always_comb begin
        if (i_cmd.rd_rst) begin
            n_rd_idx = '0;
        end else if (i_cmd.rd_adv) begin
            n_rd_idx = r_rd_idx + 1'b1;
        end else begin
            n_rd_idx = r_rd_idx;
        end
    end

    always_comb begin
        unique case (i_cmd.sel)
            SEL_START: begin n_kind = KIND_RING;  n_byte = START_BYTE;    end
            SEL_SRC:   begin n_kind = KIND_RING;  n_byte = r_src;         end
            SEL_DST:   begin n_kind = KIND_RING;  n_byte = r_dst;         end
            SEL_SIZE:  begin n_kind = KIND_RING;  n_byte = r_size;        end
            SEL_PAY:   begin n_kind = KIND_RING;  n_byte = r_rd_data;     end
            SEL_CHK:   begin n_kind = KIND_RING;  n_byte = r_chk_byte;    end
            SEL_LSRC:  begin n_kind = KIND_LOCAL; n_byte = r_src;         end
            SEL_LPAY:  begin n_kind = KIND_LOCAL; n_byte = r_rd_data;     end
            SEL_BAD:   begin n_kind = KIND_DROP;  n_byte = DROP_BAD_CHK;  end
            SEL_BIG:   begin n_kind = KIND_DROP;  n_byte = DROP_OVERSIZE; end
            default:   begin n_kind = KIND_DROP;  n_byte = DROP_BAD_CHK;  end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev <= DEV_ADDR_RST;
        end else if (i_cfg_we) begin
            r_dev <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_src) begin
            r_src <= i_rx_byte;
            r_sum <= i_rx_byte;
        end
        if (i_cmd.ld_dst) begin
            r_dst <= i_rx_byte;
            r_sum <= r_sum ^ i_rx_byte;
        end
        if (i_cmd.ld_size) begin
            r_size   <= i_rx_byte;
            r_sum    <= r_sum ^ i_rx_byte;
            r_wr_idx <= '0;
            r_left   <= o_sts.rx_over ? (9'(i_rx_byte) + 9'd1) : 9'(i_rx_byte);
        end
        if (i_cmd.data_wr) begin
            r_sum    <= r_sum ^ i_rx_byte;
            r_wr_idx <= r_wr_idx + 1'b1;
        end
        if (i_cmd.left_dec) begin
            r_left <= r_left - 9'd1;
        end
        if (i_cmd.ld_chk) begin
            r_chk_byte <= i_rx_byte;
        end
        r_rd_idx <= n_rd_idx;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.data_wr) begin
            r_mem[r_wr_idx] <= i_rx_byte;
        end
        r_rd_data <= r_mem[n_rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_kind <= n_kind;
            r_byte <= n_byte;
            r_last <= i_cmd.last;
        end
    end

    assign o_res.valid    = r_out_valid;
    assign o_res.kind     = r_kind;
    assign o_res.out_byte = r_byte;
    assign o_res.last     = r_last;

endmodule

### rtl/rpr_ctrl.sv
// ----------------------------------------------------------------------------
// rpr_ctrl
// Controller: frame parsing state machine and result burst sequencer.
// ----------------------------------------------------------------------------
module rpr_ctrl
    import rpr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRC,
        S_DST,
        S_SIZE,
        S_DATA,
        S_CHECK,
        S_SKIP,
        S_F_START,
        S_F_SRC,
        S_F_DST,
        S_F_SIZE,
        S_F_PAY,
        S_F_CHK,
        S_L_SRC,
        S_L_PAY
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   rx_phase;
    logic   acc;

    assign rx_phase   = (r_state == S_IDLE) || (r_state == S_SRC) || (r_state == S_DST)
                     || (r_state == S_SIZE) || (r_state == S_DATA)
                     || (r_state == S_CHECK) || (r_state == S_SKIP);
    assign o_in_ready = rx_phase && i_sts.out_free;
    assign acc        = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.sel = SEL_START;
        unique case (r_state)
            S_IDLE: begin
                if (acc && i_sts.rx_start) begin
                    n_state = S_SRC;
                end
            end
            S_SRC: begin
                if (acc) begin
                    o_cmd.ld_src = 1'b1;
                    n_state = S_DST;
                end
            end
            S_DST: begin
                if (acc) begin
                    o_cmd.ld_dst = 1'b1;
                    n_state = S_SIZE;
                end
            end
            S_SIZE: begin
                if (acc) begin
                    o_cmd.ld_size = 1'b1;
                    if (i_sts.rx_over) begin
                        o_cmd.emit = 1'b1;
                        o_cmd.sel  = SEL_BIG;
                        o_cmd.last = 1'b1;
                        n_state = S_SKIP;
                    end else if (i_sts.rx_zero) begin
                        n_state = S_CHECK;
                    end else begin
                        n_state = S_DATA;
                    end
                end
            end
            S_DATA: begin
                if (acc) begin
                    o_cmd.data_wr  = 1'b1;
                    o_cmd.left_dec = 1'b1;
                    if (i_sts.left_one) begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (acc) begin
                    o_cmd.ld_chk = 1'b1;
                    o_cmd.rd_rst = 1'b1;
                    if (!i_sts.rx_chk_ok) begin
                        o_cmd.emit = 1'b1;
                        o_cmd.sel  = SEL_BAD;
                        o_cmd.last = 1'b1;
                        n_state = S_IDLE;
                    end else if (i_sts.fwd) begin
                        n_state = S_F_START;
                    end else if (i_sts.dlv) begin
                        n_state = S_L_SRC;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_SKIP: begin
                if (acc) begin
                    o_cmd.left_dec = 1'b1;
                    if (i_sts.left_one) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_F_START: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.sel  = SEL_START;
                    n_state = S_F_SRC;
                end
            end
            S_F_SRC: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.sel  = SEL_SRC;
                    n_state = S_F_DST;
                end
            end
            S_F_DST: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.sel  = SEL_DST;
                    n_state = S_F_SIZE;
                end
            end
            S_F_SIZE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.sel  = SEL_SIZE;
                    n_state = i_sts.size_zero ? S_F_CHK : S_F_PAY;
                end
            end
            S_F_PAY: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.sel  = SEL_PAY;
                    if (i_sts.pay_last) begin
                        n_state = S_F_CHK;
                    end else begin
                        o_cmd.rd_adv = 1'b1;
                    end
                end
            end
            S_F_CHK: begin
                if (i_sts.out_free) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.sel    = SEL_CHK;
                    o_cmd.last   = !i_sts.dlv;
                    o_cmd.rd_rst = 1'b1;
                    n_state = i_sts.dlv ? S_L_SRC : S_IDLE;
                end
            end
            S_L_SRC: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.sel  = SEL_LSRC;
                    o_cmd.last = i_sts.size_zero;
                    n_state = i_sts.size_zero ? S_IDLE : S_L_PAY;
                end
            end
            S_L_PAY: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.sel  = SEL_LPAY;
                    o_cmd.last = i_sts.pay_last;
                    if (i_sts.pay_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.rd_adv = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef SYNTHESIS
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_sts.out_free)
        else $error("result issued into a full output register");

    a_last_ends_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && o_cmd.last) |=> rx_phase)
        else $error("burst continued after its last result");

    a_no_rx_in_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !rx_phase |-> !o_in_ready)
        else $error("byte accepted during a result burst");
`endif

endmodule

### rtl/ring_packet_receiver_forwarder.sv
// ----------------------------------------------------------------------------
// ring_packet_receiver_forwarder
// Ring frame receiver: checks frames, forwards foreign traffic, delivers
// local and broadcast traffic.
// ----------------------------------------------------------------------------
// i_rx takes one received ring byte per word. Frames are 0xAA, source,
// destination, size, payload, check byte (XOR of source..payload).
// o_res gives words of kind ring transmit, local delivery or drop notice,
// with last marking the final word caused by one received byte.
// A received byte is taken when o_res has room. A drop notice
// appears on o_res the cycle after its byte. After a good check byte the
// controller sends the burst from the output register, one word a cycle:
// size+5 forward words if foreign, then size+1 delivery words if local or
// broadcast; i_rx stays not ready for that burst. The burst rate is set
// by the single read port of the payload buffer and the output register.
// A stall on o_res holds the current word and stops both the burst and
// intake of new bytes. Reset returns the parser to start-byte hunting,
// empties the output register and sets device_address to 1. Write
// device_address over the APB port only while no frame is in flight.
// ----------------------------------------------------------------------------
module ring_packet_receiver_forwarder
    import rpr_pkg::*;
#(
    parameter int unsigned MAX_PAYLOAD = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    rpr_rx_if.sink            i_rx,
    rpr_res_if.source         o_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    t_dp_cmd    cmd;
    t_dp_sts    sts;
    logic       in_ready;
    logic       reg_hit;
    logic       cfg_we;
    logic [6:0] dev_addr;

    assign reg_hit = (paddr[ADDR_W-1:2] == REG_DEV_ADDR);
    assign cfg_we  = psel && penable && pwrite && pready && reg_hit;
    assign pready  = 1'b1;
    assign prdata  = reg_hit ? 32'(dev_addr) : 32'd0;

    assign i_rx.ready = in_ready;

    rpr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_rx.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    rpr_dp #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_byte  (i_rx.rx_byte),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (pwdata[6:0]),
        .o_dev_addr (dev_addr),
        .o_res      (o_res)
    );

endmodule

### sim/ring_packet_receiver_forwarder_tb.sv
// ----------------------------------------------------------------------------
// ring_packet_receiver_forwarder_tb
// Self-checking bench for the ring frame receiver. A scoreboard class tracks
// the frame parser and turns every accepted ring byte into the words it is
// due to produce. Every word on o_res is matched against the oldest due word.
// Stimulus is a short directed part followed by random frames: good, bad,
// oversize, truncated and noise. Bursty input and a patterned output stall
// run throughout. The device address changes over APB between phases.
// ----------------------------------------------------------------------------
module ring_packet_receiver_forwarder_tb;
    import rpr_pkg::*;

    localparam int unsigned MAX_PAYLOAD    = 16;
    localparam int          WATCHDOG_LIMIT = 4000;
    localparam int          SETTLE_CYCLES  = 2 * MAX_PAYLOAD + 16;
    localparam int          RANDOM_ITEMS   = 48;
    localparam int          PHASE_COUNT    = 4;

    localparam logic [ADDR_W-1:0] PADDR_DEV   = ADDR_W'(4 * REG_DEV_ADDR);
    localparam logic [ADDR_W-1:0] PADDR_SPARE = ADDR_W'(4);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SRC,
        PH_DST,
        PH_SIZE,
        PH_DATA,
        PH_CHECK,
        PH_SKIP
    } t_parse_phase;

    typedef enum int {
        RDY_OPEN,
        RDY_COIN,
        RDY_THIRD,
        RDY_LONG
    } t_ready_mode;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       last;
    } t_ring_word;

    class t_frame_scoreboard;
        t_parse_phase phase;
        logic [6:0]   dev_addr;
        logic [7:0]   src_addr;
        logic [7:0]   dst_addr;
        logic [7:0]   frame_size;
        logic [8:0]   bytes_left;
        logic [7:0]   run_chk;
        logic [7:0]   payload [MAX_PAYLOAD];
        t_ring_word   words_due [$];
        int           errors;

        function new();
            phase      = PH_IDLE;
            dev_addr   = DEV_ADDR_RST;
            src_addr   = '0;
            dst_addr   = '0;
            frame_size = '0;
            bytes_left = '0;
            run_chk    = '0;
            errors     = 0;
        endfunction

        function void write_register(int index, logic [31:0] value);
            if (index == int'(REG_DEV_ADDR)) begin
                dev_addr = value[6:0];
            end
        endfunction

        function void emit(logic [1:0] kind, logic [7:0] data);
            t_ring_word w;
            w.kind = kind;
            w.data = data;
            w.last = 1'b0;
            words_due.push_back(w);
        endfunction

        function void take_byte(logic [7:0] b);
            int         idx;
            int         i;
            int         first_new;
            logic [7:0] me;
            first_new = words_due.size();
            me = {1'b0, dev_addr};
            case (phase)
                PH_SRC: begin
                    src_addr = b;
                    run_chk  = b;
                    phase    = PH_DST;
                end
                PH_DST: begin
                    dst_addr = b;
                    run_chk ^= b;
                    phase    = PH_SIZE;
                end
                PH_SIZE: begin
                    frame_size = b;
                    run_chk ^= b;
                    if (b > MAX_PAYLOAD) begin
                        emit(KIND_DROP, DROP_OVERSIZE);
                        bytes_left = {1'b0, b} + 9'd1;
                        phase = PH_SKIP;
                    end else if (b == 8'd0) begin
                        bytes_left = '0;
                        phase = PH_CHECK;
                    end else begin
                        bytes_left = {1'b0, b};
                        phase = PH_DATA;
                    end
                end
                PH_DATA: begin
                    idx = int'(frame_size) - int'(bytes_left);
                    if (idx >= 0 && idx < MAX_PAYLOAD) begin
                        payload[idx] = b;
                    end
                    run_chk ^= b;
                    if (bytes_left > 0) begin
                        bytes_left--;
                    end
                    if (bytes_left == 0) begin
                        phase = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    phase = PH_IDLE;
                    if (b != run_chk) begin
                        emit(KIND_DROP, DROP_BAD_CHK);
                    end else begin
                        if (src_addr != me && dst_addr != me) begin
                            emit(KIND_RING, START_BYTE);
                            emit(KIND_RING, src_addr);
                            emit(KIND_RING, dst_addr);
                            emit(KIND_RING, frame_size);
                            for (i = 0; i < int'(frame_size); i++) begin
                                emit(KIND_RING, payload[i]);
                            end
                            emit(KIND_RING, b);
                        end
                        if (dst_addr == BROADCAST || dst_addr == me) begin
                            emit(KIND_LOCAL, src_addr);
                            for (i = 0; i < int'(frame_size); i++) begin
                                emit(KIND_LOCAL, payload[i]);
                            end
                        end
                    end
                end
                PH_SKIP: begin
                    if (bytes_left > 0) begin
                        bytes_left--;
                    end
                    if (bytes_left == 0) begin
                        phase = PH_IDLE;
                    end
                end
                default: begin
                    phase = PH_IDLE;
                    if (b == START_BYTE) begin
                        run_chk = '0;
                        phase   = PH_SRC;
                    end
                end
            endcase
            if (words_due.size() > first_new) begin
                words_due[words_due.size() - 1].last = 1'b1;
            end
        endfunction

        function void check_word(logic [1:0] kind, logic [7:0] data, logic last);
            t_ring_word want;
            if (words_due.size() == 0) begin
                $display("%0t: unexpected word exp none, got kind %0d byte %02h last %0d",
                         $time, kind, data, last);
                errors++;
            end else begin
                want = words_due.pop_front();
                if (want.kind !== kind || want.data !== data || want.last !== last) begin
                    $display({"%0t: word mismatch exp kind %0d byte %02h last %0d,",
                              " got kind %0d byte %02h last %0d"},
                             $time, want.kind, want.data, want.last, kind, data, last);
                    errors++;
                end
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    rpr_rx_if  rx ();
    rpr_res_if res ();

    t_frame_scoreboard frames;
    int                quiet_cycles;
    int                bytes_parsed;
    int                burst_left;

    ring_packet_receiver_forwarder #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx),
        .o_res   (res),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (res.valid && res.ready) begin
                frames.check_word(res.kind, res.out_byte, res.last);
            end
            if (rx.valid && rx.ready) begin
                if (frames.phase != PH_IDLE || rx.rx_byte == START_BYTE) begin
                    bytes_parsed++;
                end
                frames.take_byte(rx.rx_byte);
            end
            if ((res.valid && res.ready) || (rx.valid && rx.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
    end

    initial begin : result_stall
        t_ready_mode mode;
        int          mode_left;
        int          tick;
        mode      = RDY_OPEN;
        mode_left = 0;
        tick      = 0;
        res.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (mode_left == 0) begin
                mode      = t_ready_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 120);
            end
            mode_left--;
            tick++;
            case (mode)
                RDY_OPEN:  res.ready <= 1'b1;
                RDY_COIN:  res.ready <= 1'($urandom_range(0, 1));
                RDY_THIRD: res.ready <= (tick % 3) != 0;
                default:   res.ready <= (tick % 16) < 9;
            endcase
        end
    end

    initial begin : watchdog
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
        end
        $display("ring_packet_receiver_forwarder_tb NOT OK");
        $finish;
    end

    // Entered and left at a falling edge; valid stays high on return.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            if ($urandom_range(0, 4) != 0) begin
                gap = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 30)
                                                  : $urandom_range(1, 6);
            end
        end
        burst_left--;
        if (gap > 0) begin
            rx.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        rx.valid   <= 1'b1;
        rx.rx_byte <= b;
        @(posedge i_clk);
        while (!rx.ready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    task automatic send_frame(input logic [7:0] src, input logic [7:0] dst,
                              input logic [7:0] size, input int fill,
                              input bit corrupt, input int cut);
        logic [7:0] body [$];
        logic [7:0] chk;
        logic [7:0] p;
        int         n;
        int         i;
        body = {START_BYTE, src, dst, size};
        chk  = src ^ dst ^ size;
        for (i = 0; i < int'(size); i++) begin
            p = (fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill);
            body.push_back(p);
            chk ^= p;
        end
        body.push_back(corrupt ? chk ^ (8'h01 << $urandom_range(0, 7)) : chk);
        n = (cut >= 0 && cut < body.size()) ? cut : body.size();
        for (i = 0; i < n; i++) begin
            send_byte(body[i]);
        end
    endtask

    task automatic random_frame();
        int         pick;
        int         fill;
        logic [7:0] me;
        logic [7:0] src;
        logic [7:0] dst;
        logic [7:0] size;
        me   = {1'b0, frames.dev_addr};
        pick = $urandom_range(0, 99);
        src  = 8'($urandom_range(0, 255));
        dst  = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 5) == 0) begin
            size = $urandom_range(0, 1) ? 8'd0 : 8'(MAX_PAYLOAD);
        end else begin
            size = 8'($urandom_range(1, MAX_PAYLOAD - 1));
        end
        fill = -1;
        if ($urandom_range(0, 15) == 0) begin
            fill = $urandom_range(0, 1) ? 0 : 255;
        end
        if (pick < 25) begin
            dst = me;
        end else if (pick < 40) begin
            dst = BROADCAST;
        end else if (pick >= 62 && pick < 68) begin
            src = me;
        end
        if (pick < 80) begin
            send_frame(src, dst, size, fill, 1'b0, -1);
        end else if (pick < 86) begin
            send_frame(src, dst, size, fill, 1'b1, -1);
        end else if (pick < 91) begin
            send_frame(src, dst, 8'($urandom_range(MAX_PAYLOAD + 1, 2 * MAX_PAYLOAD + 8)),
                       -1, 1'b0, -1);
        end else if (pick < 95) begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
        end else begin
            send_frame(src, dst, size, fill, 1'b0, $urandom_range(1, int'(size) + 4));
        end
    endtask

    // Feed filler until the parser is back at start-byte hunting.
    task automatic finish_frame();
        while (frames.phase != PH_IDLE) begin
            send_byte(8'h00);
        end
    endtask

    task automatic wait_for_results();
        rx.valid <= 1'b0;
        while (frames.words_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic reg_access(input bit wr, input logic [ADDR_W-1:0] addr,
                              input logic [31:0] data);
        logic [31:0] want;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        if (wr) begin
            frames.write_register(int'(addr) / 4, data);
        end else begin
            want = {25'd0, frames.dev_addr};
            if (prdata !== want) begin
                $display("%0t: register read mismatch exp %08h got %08h",
                         $time, want, prdata);
                frames.errors++;
            end
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial begin : stimulus
        int          target;
        int          ph;
        logic [31:0] dev_value;
        frames       = new();
        quiet_cycles = 0;
        bytes_parsed = 0;
        burst_left   = 0;
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        rx.valid     = 1'b0;
        rx.rx_byte   = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        reg_access(1'b0, PADDR_DEV, '0);
        send_byte(8'h00);
        send_byte(8'h55);
        send_byte(8'hFF);
        send_frame(8'h05, 8'h01, 8'd1, 0, 1'b0, -1);
        send_frame(8'h22, BROADCAST, 8'(MAX_PAYLOAD), 255, 1'b0, -1);
        send_frame(8'h33, 8'h44, 8'd0, -1, 1'b0, -1);
        send_frame(8'h01, 8'h44, 8'd2, -1, 1'b0, -1);
        send_frame(8'h81, 8'h81, 8'd1, -1, 1'b0, -1);
        send_frame(8'h07, 8'h01, 8'd3, -1, 1'b1, -1);
        send_frame(8'h10, 8'h01, 8'(MAX_PAYLOAD + 1), -1, 1'b0, -1);
        send_frame(8'h10, 8'h01, 8'd255, -1, 1'b0, -1);
        wait_for_results();

        reg_access(1'b1, PADDR_DEV, 32'hFFFF_FFFF);
        reg_access(1'b0, PADDR_DEV, '0);
        reg_access(1'b1, PADDR_SPARE, 32'h0000_0005);
        reg_access(1'b0, PADDR_DEV, '0);
        send_frame(8'h7F, 8'h7F, 8'd3, -1, 1'b0, -1);
        send_frame(8'hFF, 8'h7F, 8'd2, -1, 1'b0, -1);
        send_frame(8'h7F, 8'h01, 8'd2, -1, 1'b0, -1);

        for (ph = 0; ph < PHASE_COUNT; ph++) begin
            finish_frame();
            wait_for_results();
            case (ph)
                0:       dev_value = 32'd0;
                1:       dev_value = 32'd127;
                default: dev_value = $urandom_range(0, 127);
            endcase
            reg_access(1'b1, PADDR_DEV, dev_value);
            reg_access(1'b0, PADDR_DEV, '0);
            target = bytes_parsed + RANDOM_ITEMS / PHASE_COUNT;
            while (bytes_parsed < target) begin
                random_frame();
            end
        end

        finish_frame();
        wait_for_results();
        if (frames.errors == 0) begin
            $display("ring_packet_receiver_forwarder_tb OK");
        end else begin
            $display("ring_packet_receiver_forwarder_tb NOT OK");
        end
        $finish;
    end
endmodule
